[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`define ASSERT_NEVER(label, clk, rst, a)

`endif

`endif

[hw/rtl/kvh_pkg.sv]
// ----------------------------------------------------------------------------
// kvh_pkg
// shared types and codes of the key-value hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvh_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 40;

  typedef logic [1:0] op_t;
  localparam op_t OP_GET = 2'd0;
  localparam op_t OP_PUT = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  typedef logic [1:0] res_t;
  localparam res_t RES_OK = 2'd0;
  localparam res_t RES_MISS = 2'd1;
  localparam res_t RES_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clr_write;
    logic load;
    logic rd_input;
    logic mod_step;
    logic rd_bucket;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } dp_sts_t;

endpackage

[hw/rtl/key_value_hash_table.sv]
// ----------------------------------------------------------------------------
// key_value_hash_table
// key-value map, BUCKETS buckets of WAYS entries, get / put / remove
// ----------------------------------------------------------------------------
// s_* carries one request: cmd (0 get, 1 put, 2 remove), key, value; m_*
//   returns one result per request: status and read value
// the bucket is key modulo BUCKETS; a put overwrites a matching key, else
//   takes the lowest free way, else reports the bucket full
// power-of-two BUCKETS: the row is read as the request is taken, compared
//   and written back in ST_EXEC, which waits while a result is stalled;
//   a new request is taken only after the last one has been written back
// other BUCKETS: a reciprocal multiply and a remainder fix-up (ST_MOD) and
//   a row read (ST_READ) come before ST_EXEC
// after rst a clearing pass writes the valid bits of every bucket row,
//   with s_tready low
// while m_tready is low the result register holds; one more request may be
//   taken and waits before its write-back until the result drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_value_hash_table #(
  parameter int BUCKETS = 128,
  parameter int WAYS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cmd[1:0], key[32:2], value[64:33], zero fill
  input  logic [kvh_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[1:0], read_value[33:2], zero fill
  output logic [kvh_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import kvh_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - VAL_W - 2;

  dp_cmd_t          ctl;
  dp_sts_t          sts;
  res_t             res_status;
  logic [VAL_W-1:0] res_value;

  kvh_ctrl #(
    .BUCKETS(BUCKETS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  kvh_dpath #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (s_tdata[1:0]),
    .in_key     (s_tdata[KEY_W+1:2]),
    .in_value   (s_tdata[KEY_W+VAL_W+1:KEY_W+2]),
    .res_status (res_status),
    .res_value  (res_value)
  );

  assign m_tdata = {PAD_W'(0), res_value, res_status};

endmodule

[hw/rtl/kvh_dpath.sv]
// ----------------------------------------------------------------------------
// kvh_dpath
// request registers, bucket remainder, bucket memory, way compare and
// result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvh_dpath #(
  parameter int BUCKETS = 128,
  parameter int WAYS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kvh_pkg::dp_cmd_t                 ctl,
  output kvh_pkg::dp_sts_t                 sts,
  input  kvh_pkg::op_t                     in_cmd,
  input  logic [kvh_pkg::KEY_W-1:0]        in_key,
  input  logic signed [kvh_pkg::VAL_W-1:0] in_value,
  output kvh_pkg::res_t                    res_status,
  output logic signed [kvh_pkg::VAL_W-1:0] res_value
);
  import kvh_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);
  localparam int SHIFT = KEY_W + BW;
  localparam longint RECIP_L =
    ((longint'(1) << SHIFT) + longint'(BUCKETS) - longint'(1)) / longint'(BUCKETS);
  localparam logic [31:0] RECIP = 32'(RECIP_L);
  localparam logic [BW-1:0] DIV_LO = BW'(BUCKETS);

  logic [WAYS-1:0]            mem_v   [BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0] mem_k   [BUCKETS];
  logic [WAYS-1:0][VAL_W-1:0] mem_val [BUCKETS];

  op_t                        req_cmd;
  logic [KEY_W-1:0]           req_key;
  logic [VAL_W-1:0]           req_value;
  logic [BW-1:0]              bucket;
  logic                       mod_phase;
  logic [BW-1:0]              quo_lo;
  logic [BW-1:0]              clr_addr;
  logic [WAYS-1:0]            rd_v;
  logic [WAYS-1:0][KEY_W-1:0] rd_k;
  logic [WAYS-1:0][VAL_W-1:0] rd_val;

  logic [KEY_W+31:0]          prod;
  logic [BW-1:0]              rem_next;
  logic [BW-1:0]              rd_addr;
  logic                       rd_en;
  logic [BW-1:0]              wr_addr;
  logic                       we_valid;
  logic [WAYS-1:0]            wr_v;

  logic [WAYS-1:0]            match;
  logic [WAYS-1:0]            hit_oh;
  logic [WAYS-1:0]            free_oh;
  logic                       hit;
  logic                       free_any;
  logic [WAYS-1:0]            row_v_next;
  logic [WAYS-1:0][KEY_W-1:0] row_k_next;
  logic [WAYS-1:0][VAL_W-1:0] row_val_next;
  logic [VAL_W-1:0]           hit_val;
  res_t                       status_next;
  logic [VAL_W-1:0]           value_next;

  // quotient by reciprocal multiply, then remainder from the low bits
  always_comb begin
    prod     = req_key * RECIP;
    rem_next = req_key[BW-1:0] - quo_lo * DIV_LO;
  end

  assign sts.mod_last = mod_phase;
  assign sts.clr_last = (clr_addr == LAST_ROW);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd   <= in_cmd;
      req_key   <= in_key;
      req_value <= in_value;
      mod_phase <= 1'b0;
      if (ctl.rd_input) begin
        bucket <= in_key[BW-1:0];
      end else begin
        bucket <= '0;
      end
    end else if (ctl.mod_step) begin
      if (!mod_phase) begin
        quo_lo    <= prod[SHIFT +: BW];
        mod_phase <= 1'b1;
      end else begin
        bucket <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_write && !sts.clr_last) begin
      clr_addr <= clr_addr + BW'(1);
    end
  end

  assign rd_addr  = ctl.rd_input ? in_key[BW-1:0] : bucket;
  assign rd_en    = ctl.rd_input || ctl.rd_bucket;
  assign wr_addr  = ctl.clr_write ? clr_addr : bucket;
  assign we_valid = ctl.clr_write || ctl.exec;
  assign wr_v     = ctl.clr_write ? '0 : row_v_next;

  always_ff @(posedge clk) begin
    if (we_valid) begin
      mem_v[wr_addr] <= wr_v;
    end
    if (ctl.exec) begin
      mem_k[bucket]   <= row_k_next;
      mem_val[bucket] <= row_val_next;
    end
    if (rd_en) begin
      rd_v   <= mem_v[rd_addr];
      rd_k   <= mem_k[rd_addr];
      rd_val <= mem_val[rd_addr];
    end
  end

  // way compare, lowest matching and lowest free way as one-hot masks
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = rd_v[w] && (rd_k[w] == req_key);
    end
    hit_oh   = match & (~match + WAYS'(1));
    free_oh  = ~rd_v & (rd_v + WAYS'(1));
    hit      = |match;
    free_any = ~&rd_v;
    hit_val  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_val = hit_val | rd_val[w];
      end
    end
  end

  always_comb begin
    row_v_next   = rd_v;
    row_k_next   = rd_k;
    row_val_next = rd_val;
    status_next  = RES_MISS;
    value_next   = '0;
    case (req_cmd)
      OP_GET: begin
        if (hit) begin
          status_next = RES_OK;
          value_next  = hit_val;
        end
      end
      OP_PUT: begin
        if (hit) begin
          status_next = RES_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
              row_val_next[w] = req_value;
            end
          end
        end else if (free_any) begin
          status_next = RES_OK;
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              row_v_next[w]   = 1'b1;
              row_k_next[w]   = req_key;
              row_val_next[w] = req_value;
            end
          end
        end else begin
          status_next = RES_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          status_next = RES_OK;
          row_v_next  = rd_v & ~hit_oh;
        end
      end
      default: begin
        status_next = RES_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= status_next;
      res_value  <= value_next;
    end
  end

endmodule

[hw/rtl/kvh_ctrl.sv]
// ----------------------------------------------------------------------------
// kvh_ctrl
// sequencer for the memory clear, request load, bucket remainder and
// execute steps, plus the result valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kvh_ctrl #(
  parameter int BUCKETS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output kvh_pkg::dp_cmd_t ctl,
  input  kvh_pkg::dp_sts_t sts
);
  import kvh_pkg::*;

  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EXEC  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load     = 1'b1;
          ctl.rd_input = IS_POW2;
          state_next   = IS_POW2 ? ST_EXEC : ST_MOD;
        end
      end
      ST_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd_bucket = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        if (!m_tvalid || m_tready) begin
          ctl.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_no_overwrite, clk, rst, ctl.exec && m_tvalid && !m_tready)
  `ASSERT_NEXT(a_exec_valid, clk, rst, ctl.exec, m_tvalid)
  `ASSERT_NEXT(a_load_advance, clk, rst, s_tvalid && s_tready, state == ST_EXEC || state == ST_MOD)
  `ASSERT_IMPLIES(a_clear_quiet, clk, rst, state == ST_CLEAR, !s_tready && !m_tvalid)

endmodule

[test/key_value_hash_table_tb.sv]
// ----------------------------------------------------------------------------
// key_value_hash_table_tb
// The testbench starts with a directed sequence that covers an empty table,
// the extreme keys and values, overwrites, a full bucket, reuse of a freed
// way and an unknown command. A random phase follows, with keys drawn mostly
// from a few hot buckets so that buckets fill up and get reused. A shadow
// copy of the bucket store predicts every result not given in the plan.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_value_hash_table_tb;
  import kvh_pkg::*;

  localparam int BUCKETS = 128;
  localparam int WAYS = 4;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int N_PLAN = 23;
  localparam int N_RAND = 1730;
  localparam int POOL = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam op_t OP_UNKNOWN = 2'd3;

  typedef struct packed {
    res_t             status;
    logic [VAL_W-1:0] read_value;
  } reply_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             typed;
    reply_t           want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  bit               slot_used [SLOTS];
  logic [KEY_W-1:0] slot_key [SLOTS];
  logic [VAL_W-1:0] slot_val [SLOTS];
  reply_t           pending [$];
  logic [6:0]       hot_bucket [8];
  bit               quiet;
  int               err_cnt, cycles, hold_cnt;
  int               n_ok, n_miss, n_full, n_get, n_put, n_remove, n_other;

  key_value_hash_table #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 5));
  endfunction

  // shadow of the bucket store, updated per request
  function automatic reply_t table_apply(op_t op, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] val);
    int     base, hit;
    reply_t r;
    base = int'(key % BUCKETS) * WAYS;
    hit = -1;
    r.status = RES_MISS;
    r.read_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit < 0 && slot_used[base+w] && slot_key[base+w] == key) hit = base + w;
    end
    case (op)
      OP_GET: begin
        if (hit >= 0) begin
          r.status = RES_OK;
          r.read_value = slot_val[hit];
        end
      end
      OP_PUT: begin
        if (hit >= 0) begin
          slot_val[hit] = val;
          r.status = RES_OK;
        end else begin
          r.status = RES_FULL;
          for (int w = 0; w < WAYS; w++) begin
            if (r.status == RES_FULL && !slot_used[base+w]) begin
              slot_used[base+w] = 1'b1;
              slot_key[base+w] = key;
              slot_val[base+w] = val;
              r.status = RES_OK;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          r.status = RES_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, reply_t exp_r, reply_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: expected status %0d value %h, got status %0d value %h",
               what, exp_r.status, exp_r.read_value, got.status, got.read_value);
    end
  endtask

  task automatic issue(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                       logic typed, reply_t want);
    int     gap;
    reply_t r;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'({val, key, op});
    do @(posedge clk); while (!s_tready);
    r = table_apply(op, key, val);
    pending.push_back(typed ? want : r);
    case (op)
      OP_GET: n_get++;
      OP_PUT: n_put++;
      OP_REMOVE: n_remove++;
      default: n_other++;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  // result side: check each response, stall at random
  always @(posedge clk) begin
    reply_t got, exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("key_value_hash_table_tb NOT OK");
      $finish;
    end else if (rst) begin
      m_tready <= 1'b0;
      hold_cnt = 0;
    end else if (m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.read_value = m_tdata[VAL_W+1:2];
      case (got.status)
        RES_OK: n_ok++;
        RES_MISS: n_miss++;
        RES_FULL: n_full++;
        default: ;
      endcase
      if (pending.size() == 0) begin
        flag_mismatch("unexpected response", '0, got);
      end else begin
        exp_r = pending.pop_front();
        if (got !== exp_r) flag_mismatch("response mismatch", exp_r, got);
      end
      hold_cnt = draw_wait();
      m_tready <= (hold_cnt == 0);
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= (hold_cnt == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    row_t             plan [N_PLAN];
    logic [KEY_W-1:0] key_pool [POOL];
    logic [KEY_W-1:0] k;
    op_t              op;
    int               roll;

    plan = '{
      '{OP_GET,     31'd0,          32'd0,          1'b1, '{RES_MISS, 32'd0}},
      '{OP_REMOVE,  31'h7fffffff,   32'd0,          1'b1, '{RES_MISS, 32'd0}},
      '{OP_PUT,     31'd0,          32'h7fffffff,   1'b1, '{RES_OK,   32'd0}},
      '{OP_GET,     31'd0,          32'hffffffff,   1'b1, '{RES_OK,   32'h7fffffff}},
      '{OP_PUT,     31'd0,          32'h80000000,   1'b1, '{RES_OK,   32'd0}},
      '{OP_GET,     31'd0,          32'd0,          1'b1, '{RES_OK,   32'h80000000}},
      '{OP_PUT,     31'd128,        32'hffffffff,   1'b1, '{RES_OK,   32'd0}},
      '{OP_PUT,     31'd256,        32'd1,          1'b1, '{RES_OK,   32'd0}},
      '{OP_PUT,     31'd384,        32'd2,          1'b1, '{RES_OK,   32'd0}},
      '{OP_PUT,     31'd512,        32'd3,          1'b1, '{RES_FULL, 32'd0}},
      '{OP_GET,     31'd512,        32'd0,          1'b1, '{RES_MISS, 32'd0}},
      '{OP_REMOVE,  31'd128,        32'd0,          1'b1, '{RES_OK,   32'd0}},
      '{OP_PUT,     31'd512,        32'd3,          1'b0, '0},
      '{OP_PUT,     31'd384,        32'h55555555,   1'b0, '0},
      '{OP_GET,     31'd384,        32'd0,          1'b0, '0},
      '{OP_GET,     31'd512,        32'd0,          1'b0, '0},
      '{OP_REMOVE,  31'd512,        32'd0,          1'b1, '{RES_OK,   32'd0}},
      '{OP_REMOVE,  31'd512,        32'd0,          1'b1, '{RES_MISS, 32'd0}},
      '{OP_UNKNOWN, 31'd0,          32'h12345678,   1'b1, '{RES_MISS, 32'd0}},
      '{OP_GET,     31'd0,          32'd0,          1'b0, '0},
      '{OP_PUT,     31'h7fffffff,   32'haaaaaaaa,   1'b1, '{RES_OK,   32'd0}},
      '{OP_GET,     31'h7fffffff,   32'd0,          1'b0, '0},
      '{OP_PUT,     31'h7fffff80,   32'h0f0f0f0f,   1'b0, '0}
    };

    // a few hot buckets, several keys each, so buckets overflow
    for (int i = 0; i < 8; i++) hot_bucket[i] = 7'($urandom_range(0, BUCKETS - 1));
    for (int i = 0; i < POOL; i++) begin
      key_pool[i][KEY_W-1:7] = 24'($urandom);
      key_pool[i][6:0] = hot_bucket[i % 8];
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PLAN; i++) begin
      issue(plan[i].op, plan[i].key, plan[i].val, plan[i].typed, plan[i].want);
    end
    drain();

    for (int i = 0; i < N_RAND; i++) begin
      quiet = ((i / 100) % 4 == 3);
      if (i == N_RAND / 2) drain();
      roll = $urandom_range(0, 99);
      op = (roll < 35) ? OP_GET : (roll < 80) ? OP_PUT : OP_REMOVE;
      roll = $urandom_range(0, 99);
      if (roll < 85) k = key_pool[$urandom_range(0, POOL - 1)];
      else if (roll < 95) k = KEY_W'($urandom);
      else if (roll < 97) k = '0;
      else k = '1;
      issue(op, k, 32'($urandom), 1'b0, '0);
    end
    quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    if (pending.size() != 0) flag_mismatch("missing response", pending[0], '0);
    $display("requests: %0d get, %0d put, %0d remove, %0d unknown command",
             n_get, n_put, n_remove, n_other);
    $display("responses: %0d done or hit, %0d miss, %0d bucket full, %0d errors",
             n_ok, n_miss, n_full, err_cnt);
    if (err_cnt == 0) begin
      $display("key_value_hash_table_tb OK");
    end else begin
      $display("key_value_hash_table_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/kvh_pkg.sv
hw/rtl/kvh_dpath.sv
hw/rtl/kvh_ctrl.sv
hw/rtl/key_value_hash_table.sv
test/key_value_hash_table_tb.sv
